// ===== rtl/utrr_pkg.sv =====
// Shared types and constants for the UART transmit/receive ring engine.
`timescale 1ns / 1ps

package utrr_pkg;

   localparam int unsigned BYTE_W = 8;

   // Received byte that raises the Ctrl-C flag.
   localparam logic [BYTE_W-1:0] CTRL_C = 8'h03;

   typedef enum logic [1:0] {
      REQ_PUT     = 2'd0,
      REQ_GET     = 2'd1,
      REQ_RX_BYTE = 2'd2,
      REQ_TX_SLOT = 2'd3
   } req_kind_type;

endpackage

// ===== rtl/uart_tx_rx_ring_engine.sv =====
// UART transmit and receive ring buffers with put, get, receive and drain items.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  req_type, req_data_byte
//   rsp_      out        rsp_valid / rsp_ready  eleven result fields
//   csr_      in         csr_valid / csr_ready  csr_irq_mode
//
// One item is taken per cycle while no stalled result blocks the input; its
// result appears in the cycle after acceptance. The ring memories are read at
// the accept edge; the registered read port of each memory is the result stage.
// A stalled result holds, and a new item is taken in the same cycle the old
// result leaves. Synchronous reset empties both rings and selects polling mode.
`timescale 1ns / 1ps

module uart_tx_rx_ring_engine
   import utrr_pkg::*;
#(
   parameter int unsigned TX_DEPTH = 256,
   parameter int unsigned RX_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [BYTE_W-1:0] req_data_byte,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_tx_valid,
   output logic [BYTE_W-1:0] rsp_tx_byte,
   output logic              rsp_put_accepted,
   output logic              rsp_get_valid,
   output logic [BYTE_W-1:0] rsp_get_byte,
   output logic              rsp_rx_dropped,
   output logic              rsp_ctrl_c_seen,
   output logic              rsp_rx_notify,
   output logic              rsp_tx_irq_armed,
   output logic              rsp_rx_available,
   output logic              rsp_tx_ring_empty,

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_irq_mode
);

   localparam int unsigned TX_AW = $clog2(TX_DEPTH);
   localparam int unsigned RX_AW = $clog2(RX_DEPTH);
   localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
   localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

   logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
   logic [BYTE_W-1:0] rx_mem [RX_DEPTH];

   logic              irq_mode_ff;
   logic [TX_AW-1:0]  tx_wr_ptr_ff, tx_wr_ptr_in;
   logic [TX_AW-1:0]  tx_rd_ptr_ff, tx_rd_ptr_in;
   // Receive pointers are an entry index plus a lap bit, so a full ring and
   // an empty ring can be told apart.
   logic [RX_AW-1:0]  rx_wr_idx_ff, rx_wr_idx_in;
   logic [RX_AW-1:0]  rx_rd_idx_ff, rx_rd_idx_in;
   logic              rx_wr_lap_ff, rx_wr_lap_in;
   logic              rx_rd_lap_ff, rx_rd_lap_in;
   logic              tx_irq_en_ff, tx_irq_en_in;

   logic              rsp_valid_ff;
   logic              tx_valid_ff, tx_valid_in;
   logic              tx_from_ring_ff, tx_from_ring_in;
   logic [BYTE_W-1:0] tx_byte_ff, tx_byte_in;
   logic              put_ok_ff, put_ok_in;
   logic              get_valid_ff, get_valid_in;
   logic              dropped_ff, dropped_in;
   logic              ctrl_c_ff, ctrl_c_in;
   logic              notify_ff, notify_in;
   logic [BYTE_W-1:0] tx_rd_data_ff;
   logic [BYTE_W-1:0] rx_rd_data_ff;

   logic              req_fire;
   logic              tx_wr_en, rx_wr_en;
   logic [TX_AW-1:0]  tx_wr_next, tx_rd_next;
   logic [RX_AW-1:0]  rx_wr_idx_next, rx_rd_idx_next;
   logic              tx_full, tx_empty, rx_full, rx_empty;
   req_kind_type      kind;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign kind      = req_kind_type'(req_type);

   assign tx_wr_next     = (tx_wr_ptr_ff == TX_LAST) ? '0 : tx_wr_ptr_ff + TX_AW'(1);
   assign tx_rd_next     = (tx_rd_ptr_ff == TX_LAST) ? '0 : tx_rd_ptr_ff + TX_AW'(1);
   assign rx_wr_idx_next = (rx_wr_idx_ff == RX_LAST) ? '0 : rx_wr_idx_ff + RX_AW'(1);
   assign rx_rd_idx_next = (rx_rd_idx_ff == RX_LAST) ? '0 : rx_rd_idx_ff + RX_AW'(1);

   assign tx_full  = (tx_wr_next == tx_rd_ptr_ff);
   assign tx_empty = (tx_wr_ptr_ff == tx_rd_ptr_ff);
   assign rx_empty = (rx_wr_idx_ff == rx_rd_idx_ff) && (rx_wr_lap_ff == rx_rd_lap_ff);
   assign rx_full  = (rx_wr_idx_ff == rx_rd_idx_ff) && (rx_wr_lap_ff != rx_rd_lap_ff);

   always_comb begin
      tx_wr_ptr_in    = tx_wr_ptr_ff;
      tx_rd_ptr_in    = tx_rd_ptr_ff;
      rx_wr_idx_in    = rx_wr_idx_ff;
      rx_rd_idx_in    = rx_rd_idx_ff;
      rx_wr_lap_in    = rx_wr_lap_ff;
      rx_rd_lap_in    = rx_rd_lap_ff;
      tx_irq_en_in    = tx_irq_en_ff;
      tx_valid_in     = 1'b0;
      tx_from_ring_in = 1'b0;
      tx_byte_in      = '0;
      put_ok_in       = 1'b0;
      get_valid_in    = 1'b0;
      dropped_in      = 1'b0;
      ctrl_c_in       = 1'b0;
      notify_in       = 1'b0;
      tx_wr_en        = 1'b0;
      rx_wr_en        = 1'b0;
      unique case (kind)
         REQ_PUT: begin
            if (!irq_mode_ff) begin
               tx_valid_in = 1'b1;
               tx_byte_in  = req_data_byte;
               put_ok_in   = 1'b1;
            end else if (!tx_full) begin
               tx_wr_en     = 1'b1;
               tx_wr_ptr_in = tx_wr_next;
               tx_irq_en_in = 1'b1;
               put_ok_in    = 1'b1;
            end
         end
         REQ_GET: begin
            if (!rx_empty) begin
               get_valid_in = 1'b1;
               rx_rd_idx_in = rx_rd_idx_next;
               rx_rd_lap_in = (rx_rd_idx_ff == RX_LAST) ? !rx_rd_lap_ff : rx_rd_lap_ff;
            end
         end
         REQ_RX_BYTE: begin
            ctrl_c_in = (req_data_byte == CTRL_C);
            notify_in = 1'b1;
            if (rx_full) begin
               dropped_in = 1'b1;
            end else begin
               rx_wr_en     = 1'b1;
               rx_wr_idx_in = rx_wr_idx_next;
               rx_wr_lap_in = (rx_wr_idx_ff == RX_LAST) ? !rx_wr_lap_ff : rx_wr_lap_ff;
            end
         end
         REQ_TX_SLOT: begin
            // The drain also runs in polling mode to flush leftover bytes.
            if (!tx_empty) begin
               tx_valid_in     = 1'b1;
               tx_from_ring_in = 1'b1;
               tx_rd_ptr_in    = tx_rd_next;
               if (tx_rd_next == tx_wr_ptr_ff) begin
                  tx_irq_en_in = 1'b0;
               end
            end else begin
               tx_irq_en_in = 1'b0;
            end
         end
         default: begin
            tx_irq_en_in = tx_irq_en_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_mode_ff  <= 1'b0;
         tx_wr_ptr_ff <= '0;
         tx_rd_ptr_ff <= '0;
         rx_wr_idx_ff <= '0;
         rx_rd_idx_ff <= '0;
         rx_wr_lap_ff <= 1'b0;
         rx_rd_lap_ff <= 1'b0;
         tx_irq_en_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            irq_mode_ff <= csr_irq_mode;
         end
         if (req_fire) begin
            tx_wr_ptr_ff <= tx_wr_ptr_in;
            tx_rd_ptr_ff <= tx_rd_ptr_in;
            rx_wr_idx_ff <= rx_wr_idx_in;
            rx_rd_idx_ff <= rx_rd_idx_in;
            rx_wr_lap_ff <= rx_wr_lap_in;
            rx_rd_lap_ff <= rx_rd_lap_in;
            tx_irq_en_ff <= tx_irq_en_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result fields carry no reset; they are qualified by rsp_valid.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         tx_valid_ff     <= tx_valid_in;
         tx_from_ring_ff <= tx_from_ring_in;
         tx_byte_ff      <= tx_byte_in;
         put_ok_ff       <= put_ok_in;
         get_valid_ff    <= get_valid_in;
         dropped_ff      <= dropped_in;
         ctrl_c_ff       <= ctrl_c_in;
         notify_ff       <= notify_in;
      end
   end

   // Ring memories: at most one write and one registered read per item.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (tx_wr_en) begin
            tx_mem[tx_wr_ptr_ff] <= req_data_byte;
         end
         tx_rd_data_ff <= tx_mem[tx_rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (rx_wr_en) begin
            rx_mem[rx_wr_idx_ff] <= req_data_byte;
         end
         rx_rd_data_ff <= rx_mem[rx_rd_idx_ff];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_valid      = tx_valid_ff;
   assign rsp_tx_byte       = tx_from_ring_ff ? tx_rd_data_ff : tx_byte_ff;
   assign rsp_put_accepted  = put_ok_ff;
   assign rsp_get_valid     = get_valid_ff;
   assign rsp_get_byte      = get_valid_ff ? rx_rd_data_ff : '0;
   assign rsp_rx_dropped    = dropped_ff;
   assign rsp_ctrl_c_seen   = ctrl_c_ff;
   assign rsp_rx_notify     = notify_ff;
   // Ring state changes only when an item is taken, so it matches the held result.
   assign rsp_tx_irq_armed  = tx_irq_en_ff;
   assign rsp_rx_available  = !rx_empty;
   assign rsp_tx_ring_empty = tx_empty;

   a_irq_needs_bytes: assert property (@(posedge clock) disable iff (reset)
      tx_irq_en_ff |-> !tx_empty)
      else $error("transmit interrupt armed with an empty ring");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rx_dropped) |-> (rx_full && rsp_rx_notify))
      else $error("received byte dropped while the ring had room");

   a_get_excludes_tx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_get_valid) |-> (!rsp_tx_valid && !rsp_put_accepted))
      else $error("get result also reports transmit activity");

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("accepted item produced no result");

   a_drain_flags_tx: assert property (@(posedge clock) disable iff (reset)
      (req_fire && kind == REQ_TX_SLOT && !tx_empty) |=> (rsp_tx_valid && tx_from_ring_ff))
      else $error("drain of a non-empty ring sent nothing");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the UART transmit and receive ring engine.
`timescale 1ns / 1ps

module testbench
   import utrr_pkg::*;
();

   localparam logic MODE_POLL = 1'b0;
   localparam logic MODE_IRQ  = 1'b1;
   localparam int unsigned IDLE_PCT    = 38;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct {
      req_kind_type      kind;
      logic [BYTE_W-1:0] data;
   } ring_req_type;

   typedef struct packed {
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              put_accepted;
      logic              get_valid;
      logic [BYTE_W-1:0] get_byte;
      logic              rx_dropped;
      logic              ctrl_c_seen;
      logic              rx_notify;
      logic              tx_irq_armed;
      logic              rx_available;
      logic              tx_ring_empty;
   } ring_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_type = REQ_PUT;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_tx_valid;
   logic [BYTE_W-1:0] rsp_tx_byte;
   logic              rsp_put_accepted;
   logic              rsp_get_valid;
   logic [BYTE_W-1:0] rsp_get_byte;
   logic              rsp_rx_dropped;
   logic              rsp_ctrl_c_seen;
   logic              rsp_rx_notify;
   logic              rsp_tx_irq_armed;
   logic              rsp_rx_available;
   logic              rsp_tx_ring_empty;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_irq_mode = MODE_POLL;

   uart_tx_rx_ring_engine dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_put_accepted  (rsp_put_accepted),
      .rsp_get_valid     (rsp_get_valid),
      .rsp_get_byte      (rsp_get_byte),
      .rsp_rx_dropped    (rsp_rx_dropped),
      .rsp_ctrl_c_seen   (rsp_ctrl_c_seen),
      .rsp_rx_notify     (rsp_rx_notify),
      .rsp_tx_irq_armed  (rsp_tx_irq_armed),
      .rsp_rx_available  (rsp_rx_available),
      .rsp_tx_ring_empty (rsp_tx_ring_empty),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_irq_mode      (csr_irq_mode)
   );

   always #5 clock = ~clock;

   // Shadow of the engine: mode, both rings and the interrupt enable.
   logic              shadow_mode = MODE_POLL;
   logic [BYTE_W-1:0] tx_ring [256];
   logic [BYTE_W-1:0] rx_ring [64];
   bit   [7:0]        tx_head = '0;
   bit   [7:0]        tx_tail = '0;
   bit   [6:0]        rx_head = '0;
   bit   [6:0]        rx_tail = '0;
   logic              tx_armed = 1'b0;

   ring_req_type req_backlog [$];
   ring_rsp_type predicted_rsp [$];
   ring_req_type offered;
   logic        no_idle = 1'b0;
   logic        hold_req = 1'b0;
   logic        hold_rsp = 1'b0;
   int unsigned mismatches = 0;
   int unsigned items_taken = 0;
   int unsigned puts_refused = 0;
   int unsigned bytes_dropped = 0;
   int unsigned ctrl_c_bytes = 0;
   int unsigned gets_empty = 0;
   int unsigned cycles = 0;

   function automatic ring_rsp_type advance_rings(req_kind_type kind, logic [BYTE_W-1:0] b);
      ring_rsp_type r;
      bit   [6:0] rx_fill;
      r = '0;
      case (kind)
         REQ_PUT: begin
            if (shadow_mode == MODE_POLL) begin
               r.tx_valid     = 1'b1;
               r.tx_byte      = b;
               r.put_accepted = 1'b1;
            end else if (8'(tx_head + 8'd1) != tx_tail) begin
               tx_ring[tx_head] = b;
               tx_head          = tx_head + 8'd1;
               tx_armed         = 1'b1;
               r.put_accepted   = 1'b1;
            end else begin
               puts_refused++;
            end
         end
         REQ_GET: begin
            if (rx_head != rx_tail) begin
               r.get_valid = 1'b1;
               r.get_byte  = rx_ring[rx_tail[5:0]];
               rx_tail     = rx_tail + 7'd1;
            end else begin
               gets_empty++;
            end
         end
         REQ_RX_BYTE: begin
            r.rx_notify   = 1'b1;
            r.ctrl_c_seen = (b == CTRL_C);
            if (r.ctrl_c_seen) ctrl_c_bytes++;
            rx_fill = rx_head - rx_tail;
            if (!rx_fill[6]) begin
               rx_ring[rx_head[5:0]] = b;
               rx_head               = rx_head + 7'd1;
            end else begin
               r.rx_dropped = 1'b1;
               bytes_dropped++;
            end
         end
         default: begin
            // A free transmit slot drains the ring whatever the mode.
            if (tx_head != tx_tail) begin
               r.tx_valid = 1'b1;
               r.tx_byte  = tx_ring[tx_tail];
               tx_tail    = tx_tail + 8'd1;
            end
            if (tx_head == tx_tail) tx_armed = 1'b0;
         end
      endcase
      r.tx_irq_armed  = tx_armed;
      r.rx_available  = (rx_head != rx_tail);
      r.tx_ring_empty = (tx_head == tx_tail);
      return r;
   endfunction

   function automatic void check_field(string name, logic [BYTE_W-1:0] want,
                                       logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Sender: one item offered at a time, held until the engine takes it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_rsp.push_back(advance_rings(offered.kind, offered.data));
            items_taken++;
         end
         if (!req_valid || req_ready) begin
            if (req_backlog.size() != 0 &&
                (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
               offered = req_backlog.pop_front();
               req_valid     <= 1'b1;
               req_type      <= offered.kind;
               req_data_byte <= offered.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: compares every result taken with the oldest prediction.
   always @(posedge clock) begin
      ring_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               $error("result arrived with no item outstanding");
               mismatches++;
            end else begin
               want = predicted_rsp.pop_front();
               check_field("tx_valid", BYTE_W'(want.tx_valid), BYTE_W'(rsp_tx_valid));
               check_field("tx_byte", want.tx_byte, rsp_tx_byte);
               check_field("put_accepted", BYTE_W'(want.put_accepted),
                           BYTE_W'(rsp_put_accepted));
               check_field("get_valid", BYTE_W'(want.get_valid), BYTE_W'(rsp_get_valid));
               check_field("get_byte", want.get_byte, rsp_get_byte);
               check_field("rx_dropped", BYTE_W'(want.rx_dropped), BYTE_W'(rsp_rx_dropped));
               check_field("ctrl_c_seen", BYTE_W'(want.ctrl_c_seen),
                           BYTE_W'(rsp_ctrl_c_seen));
               check_field("rx_notify", BYTE_W'(want.rx_notify), BYTE_W'(rsp_rx_notify));
               check_field("tx_irq_armed", BYTE_W'(want.tx_irq_armed),
                           BYTE_W'(rsp_tx_irq_armed));
               check_field("rx_available", BYTE_W'(want.rx_available),
                           BYTE_W'(rsp_rx_available));
               check_field("tx_ring_empty", BYTE_W'(want.tx_ring_empty),
                           BYTE_W'(rsp_tx_ring_empty));
            end
         end
         rsp_ready <= !hold_rsp && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Long receiver hold-off so the result stage backs up into the input.
   initial begin
      wait (hold_req);
      @(negedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_rsp = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic queue_req(req_kind_type kind, logic [BYTE_W-1:0] data);
      ring_req_type item;
      item.kind = kind;
      item.data = data;
      req_backlog.push_back(item);
   endtask

   // Runs of one kind, or short runs of random kinds, with random content, so both rings fill and drain deeply.
   task automatic queue_traffic(int unsigned count);
      int unsigned  left;
      int unsigned  run;
      int unsigned  pick;
      req_kind_type kind;
      logic [BYTE_W-1:0] data;
      left = count;
      while (left > 0) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2: begin
               kind = REQ_PUT;
               run  = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 280)
                                                  : $urandom_range(1, 12);
            end
            3, 4: begin
               kind = REQ_TX_SLOT;
               run  = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 20);
            end
            5, 6: begin
               kind = REQ_RX_BYTE;
               run  = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 90)
                                                  : $urandom_range(1, 12);
            end
            7, 8: begin
               kind = REQ_GET;
               run  = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 90)
                                                  : $urandom_range(1, 12);
            end
            default: begin
               kind = REQ_PUT;
               run  = $urandom_range(1, 3);
            end
         endcase
         if (run > left) run = left;
         repeat (run) begin
            if (pick == 9) kind = req_kind_type'($urandom_range(0, 3));
            data = ($urandom_range(0, 7) == 0) ? CTRL_C : BYTE_W'($urandom_range(0, 255));
            queue_req(kind, data);
         end
         left -= run;
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || predicted_rsp.size() != 0);
   endtask

   task automatic write_mode(logic mode);
      @(posedge clock);
      csr_valid    <= 1'b1;
      csr_irq_mode <= mode;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid   <= 1'b0;
      shadow_mode = mode;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Polling mode from reset: empty get, empty drain, direct puts, Ctrl-C.
      queue_req(REQ_GET, 8'hFF);
      queue_req(REQ_TX_SLOT, 8'h00);
      queue_req(REQ_PUT, 8'h00);
      queue_req(REQ_PUT, 8'hFF);
      queue_req(REQ_PUT, 8'h5A);
      queue_req(REQ_RX_BYTE, CTRL_C);
      queue_req(REQ_RX_BYTE, 8'h00);
      queue_req(REQ_RX_BYTE, 8'hFF);
      repeat (4) queue_req(REQ_GET, 8'hA5);
      wait_idle();

      // Interrupt mode leaves bytes behind, which then drain in polling mode.
      write_mode(MODE_IRQ);
      queue_req(REQ_PUT, 8'hFF);
      queue_req(REQ_PUT, 8'h00);
      queue_req(REQ_PUT, 8'hA5);
      queue_req(REQ_TX_SLOT, 8'h3C);
      wait_idle();
      write_mode(MODE_POLL);
      repeat (3) queue_req(REQ_TX_SLOT, 8'hC3);
      wait_idle();

      write_mode(MODE_IRQ);
      queue_traffic(300);
      wait_idle();

      write_mode(MODE_POLL);
      queue_traffic(250);
      hold_req = 1'b1;
      wait_idle();

      // Overfill the transmit ring so at least one put is refused.
      write_mode(MODE_IRQ);
      repeat (256) queue_req(REQ_PUT, BYTE_W'($urandom_range(0, 255)));
      queue_traffic(250);
      wait_idle();

      write_mode(MODE_POLL);
      no_idle = 1'b1;
      queue_traffic(250);
      wait_idle();
      no_idle = 1'b0;

      write_mode(MODE_IRQ);
      queue_traffic(150);
      wait_idle();
      repeat (4) @(posedge clock);

      $display("Ran %0d items through both modes, with a long result hold-off.", items_taken);
      $display("Saw %0d refused puts, %0d dropped bytes, %0d Ctrl-C bytes, %0d empty gets.",
               puts_refused, bytes_dropped, ctrl_c_bytes, gets_empty);
      if (mismatches == 0 && predicted_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
